// File: rtl/core/cbd_pkg.sv
// Shared constants, types and the hex digit decoder for the chunked body
// decoder. No dependencies.
package cbd_pkg;

  localparam int SIZE_BITS_DEF = 31;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  // One input word after the input register
  typedef struct packed {
    logic       valid;
    logic       start_req;
    logic [7:0] data;
  } cbd_word_t;

  // One result word from the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       end_of_body;
  } cbd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } cbd_hex_t;

  function automatic cbd_hex_t hex_digit(input logic [7:0] b);
    cbd_hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.value = 4'(b - 8'h30);
    end else if (b inside {[8'h41:8'h46]}) begin
      h.value = 4'(b - 8'h37);
    end else if (b inside {[8'h61:8'h66]}) begin
      h.value = 4'(b - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/core/cbd_in_stage.sv
// Input register of the chunked body decoder: holds one word until the
// parser takes it. Depends on cbd_pkg.
module cbd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_start_req,
  input  logic [7:0]         in_byte,
  output logic               in_stall,
  input  logic               advance,
  output cbd_pkg::cbd_word_t word
);
  import cbd_pkg::*;

  logic       v_r;
  logic       start_r;
  logic [7:0] data_r;

  assign in_stall = v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!in_stall) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      start_r <= in_start_req;
      data_r  <= in_byte;
    end
  end

  assign word.valid     = v_r;
  assign word.start_req = start_r;
  assign word.data      = data_r;

endmodule

// File: rtl/core/cbd_parse.sv
// Parser state and one-byte step logic of the chunked body decoder.
// Depends on cbd_pkg.
module cbd_parse #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  cbd_pkg::cbd_word_t word,
  output cbd_pkg::cbd_res_t  res
);
  import cbd_pkg::*;

  localparam logic [2:0] PH_WS       = 3'd0;
  localparam logic [2:0] PH_NUMSTART = 3'd1;
  localparam logic [2:0] PH_PREFIX   = 3'd2;
  localparam logic [2:0] PH_DIGITS   = 3'd3;
  localparam logic [2:0] PH_EXT      = 3'd4;
  localparam logic [2:0] PH_EXTCR    = 3'd5;
  localparam logic [2:0] PH_DATA     = 3'd6;
  localparam logic [2:0] PH_DONE     = 3'd7;

  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic                 minus_r, minus_nxt;
  logic                 dseen_r, dseen_nxt;
  logic                 sat_r, sat_nxt;
  logic [1:0]           trl_r, trl_nxt;

  logic [2:0]           ph_e;
  logic [SIZE_BITS-1:0] acc_e;
  logic [SIZE_BITS-1:0] rem_e;
  logic                 minus_e;
  logic                 dseen_e;
  logic                 sat_e;
  logic [1:0]           trl_e;
  logic                 do_num;
  logic                 do_digit;
  logic [7:0]           b;
  cbd_hex_t             hx;

  assign b  = word.data;
  assign hx = hex_digit(b);

  always_comb begin
    // start of a new body: step from the reset state
    ph_e    = word.start_req ? PH_WS : phase_r;
    acc_e   = word.start_req ? '0 : acc_r;
    rem_e   = word.start_req ? '0 : rem_r;
    minus_e = word.start_req ? 1'b0 : minus_r;
    dseen_e = word.start_req ? 1'b0 : dseen_r;
    sat_e   = word.start_req ? 1'b0 : sat_r;
    trl_e   = word.start_req ? 2'd0 : trl_r;

    phase_nxt = ph_e;
    acc_nxt   = acc_e;
    rem_nxt   = rem_e;
    minus_nxt = minus_e;
    dseen_nxt = dseen_e;
    sat_nxt   = sat_e;
    trl_nxt   = trl_e;
    do_num    = 1'b0;
    do_digit  = 1'b0;
    res       = '0;

    case (ph_e)
      PH_WS: begin
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
          phase_nxt = PH_WS;
        end else if (b == CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = PH_NUMSTART;
        end else if (b == CH_PLUS) begin
          phase_nxt = PH_NUMSTART;
        end else begin
          do_num = 1'b1;
        end
      end
      PH_NUMSTART: do_num = 1'b1;
      PH_PREFIX: begin
        phase_nxt = PH_DIGITS;
        if (b != CH_X_LO && b != CH_X_UP) begin
          dseen_nxt = 1'b1;
          do_digit  = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      PH_EXT: begin
        if (b == CH_CR) begin
          phase_nxt = PH_EXTCR;
        end
      end
      PH_EXTCR: begin
        if (b == CH_LF) begin
          rem_nxt   = acc_e;
          trl_nxt   = 2'd2;
          phase_nxt = PH_DATA;
        end else if (b != CH_CR) begin
          phase_nxt = PH_EXT;
        end
      end
      PH_DATA: begin
        if (rem_e != '0) begin
          rem_nxt  = rem_e - SIZE_BITS'(1);
          res.valid = 1'b1;
          res.data  = b;
        end else begin
          trl_nxt = (trl_e != 2'd0) ? trl_e - 2'd1 : 2'd0;
          if (trl_nxt == 2'd0) begin
            acc_nxt   = '0;
            minus_nxt = 1'b0;
            dseen_nxt = 1'b0;
            sat_nxt   = 1'b0;
            phase_nxt = PH_WS;
          end
        end
      end
      default: phase_nxt = ph_e;
    endcase

    // a leading zero may open a 0x prefix
    if (do_num) begin
      if (b == CH_ZERO) begin
        phase_nxt = PH_PREFIX;
      end else begin
        phase_nxt = PH_DIGITS;
        do_digit  = 1'b1;
      end
    end

    if (do_digit) begin
      if (!hx.ok) begin
        // close the size field
        if (minus_nxt || !dseen_nxt || acc_e == '0) begin
          phase_nxt       = PH_DONE;
          res.valid       = 1'b1;
          res.data        = 8'd0;
          res.end_of_body = 1'b1;
        end else begin
          phase_nxt = (b == CH_CR) ? PH_EXTCR : PH_EXT;
        end
      end else begin
        dseen_nxt = 1'b1;
        // the shift overflows exactly when the top nibble is non-zero
        if (sat_e || acc_e[SIZE_BITS-1 -: 4] != 4'd0) begin
          sat_nxt = 1'b1;
          acc_nxt = SIZE_MAX;
        end else begin
          acc_nxt = {acc_e[SIZE_BITS-5:0], hx.value};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      acc_r   <= '0;
      rem_r   <= '0;
      minus_r <= 1'b0;
      dseen_r <= 1'b0;
      sat_r   <= 1'b0;
      trl_r   <= 2'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      minus_r <= minus_nxt;
      dseen_r <= dseen_nxt;
      sat_r   <= sat_nxt;
      trl_r   <= trl_nxt;
    end
  end

endmodule

// File: rtl/core/cbd_out_stage.sv
// Result register of the chunked body decoder: holds one result word while
// the output is stalled. Depends on cbd_pkg.
module cbd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  cbd_pkg::cbd_res_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_end_of_body,
  output logic              advance
);
  import cbd_pkg::*;

  logic       v_r;
  logic [7:0] data_r;
  logic       eob_r;

  assign advance = !v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (advance) begin
      v_r <= step_en && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.valid) begin
      data_r <= res.data;
      eob_r  <= res.end_of_body;
    end
  end

  assign out_valid       = v_r;
  assign out_byte        = data_r;
  assign out_end_of_body = eob_r;

endmodule

// File: rtl/core/chunked_body_decoder.sv
// Top level of the chunked transfer body decoder: input register, parser
// and result register. Depends on cbd_pkg, cbd_in_stage, cbd_parse, cbd_out_stage.
//
//   channel  direction  ports
//   in       input      in_valid, in_stall, in_start_req, in_byte
//   out      output     out_valid, out_stall, out_byte, out_end_of_body
//
// One word is taken every cycle unless the input is stalled; a word that yields
// a result leaves through the input register, then the result register.
// The size field is updated with a single shift-and-insert per word.
// Reset is synchronous and clears the parser to the start of a size field.
// A stall on the output while a result is held halts the parser and, in the same cycle, the input.
module chunked_body_decoder #(
  parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_start_req,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_end_of_body
);
  import cbd_pkg::*;

  cbd_word_t word;
  cbd_res_t  res;
  logic      advance;
  logic      step_en;

  assign step_en = word.valid && advance;

  cbd_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_start_req(in_start_req),
    .in_byte     (in_byte),
    .in_stall    (in_stall),
    .advance     (advance),
    .word        (word)
  );

  cbd_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .word   (word),
    .res    (res)
  );

  cbd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .res            (res),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_end_of_body(out_end_of_body),
    .advance        (advance)
  );

`ifndef ASSERT_OFF
  a_eob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_body |-> out_byte == 8'd0)
    else $error("end marker carries a non-zero byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> word.valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_no_step_on_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !step_en)
    else $error("parser stepped while result register blocked");
`endif

endmodule

// File: bench/chunked_body_decoder_tb.sv
// Self-checking bench for chunked_body_decoder: feeds chunked bodies byte by byte, predicts
// each payload byte and end marker, and checks them on the result channel.
// Depends on cbd_pkg and the chunked_body_decoder RTL.
module chunked_body_decoder_tb;
  import cbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 1200;
  localparam int STEADY_WORDS   = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam longint unsigned SIZE_MAX = (64'd1 << SIZE_BITS_DEF) - 64'd1;

  typedef enum logic [2:0] {
    P_WS, P_NUMSTART, P_PREFIX, P_DIGITS, P_EXT, P_EXTCR, P_DATA, P_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } body_out_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  wire        in_stall;
  logic       in_start_req = 1'b0;
  logic [7:0] in_byte = 8'h00;
  wire        out_valid;
  logic       out_stall = 1'b0;
  wire  [7:0] out_byte;
  wire        out_end_of_body;

  chunked_body_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_req   (in_start_req),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_end_of_body(out_end_of_body)
  );

  // Predicted parser state
  parse_phase_t    pp = P_WS;
  longint unsigned size_acc = 0;
  longint unsigned bytes_left = 0;
  logic            minus_seen = 1'b0;
  logic            digit_seen = 1'b0;
  logic            saturated = 1'b0;
  int              trailer_left = 0;

  body_out_t expected_q[$];
  int  failures = 0;
  int  words_sent = 0;
  int  words_ignored = 0;
  int  results_checked = 0;
  int  bodies_ended = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  open_body = 1'b0;
  bit  gaps_on = 1'b1;

  string body_enders [6] = '{"0\r\n\r\n", "-1a\r\n", "0x\r\n", "\r\n", "000;x\r\n",
                             "+0X0\r\n"};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_size_field();
    size_acc   = 0;
    minus_seen = 1'b0;
    digit_seen = 1'b0;
    saturated  = 1'b0;
  endtask

  task automatic decode_word(input logic start, input logic [7:0] b);
    int unsigned d;
    logic        to_number;
    logic        to_digits;
    to_number = 1'b0;
    to_digits = 1'b0;
    if (start) begin
      clear_size_field();
      bytes_left   = 0;
      trailer_left = 0;
      pp           = P_WS;
    end
    if (pp == P_DONE) words_ignored++;
    else words_sent++;
    case (pp)
      P_WS: begin
        if (b == CH_MINUS) begin
          minus_seen = 1'b1;
          pp = P_NUMSTART;
        end else if (b == CH_PLUS) begin
          pp = P_NUMSTART;
        end else if (b != CH_SPACE && b != CH_TAB && b != CH_LF) begin
          to_number = 1'b1;
        end
      end
      P_NUMSTART: to_number = 1'b1;
      P_PREFIX: begin
        pp = P_DIGITS;
        if (b != CH_X_UP && b != CH_X_LO) begin
          digit_seen = 1'b1;
          to_digits  = 1'b1;
        end
      end
      P_DIGITS: to_digits = 1'b1;
      P_EXT: if (b == CH_CR) pp = P_EXTCR;
      P_EXTCR: begin
        if (b == CH_LF) begin
          bytes_left   = size_acc & SIZE_MAX;
          trailer_left = 2;
          pp           = P_DATA;
        end else if (b != CH_CR) begin
          pp = P_EXT;
        end
      end
      P_DATA: begin
        if (bytes_left > 0) begin
          bytes_left--;
          expected_q.push_back('{data: b, eob: 1'b0});
        end else begin
          if (trailer_left > 0) trailer_left--;
          if (trailer_left == 0) begin
            clear_size_field();
            pp = P_WS;
          end
        end
      end
      default: ;
    endcase
    if (to_number) begin
      if (b == CH_ZERO) begin
        pp = P_PREFIX;
      end else begin
        pp = P_DIGITS;
        to_digits = 1'b1;
      end
    end
    if (to_digits) begin
      if (b >= "0" && b <= "9") d = 32'(b - "0");
      else if (b >= "A" && b <= "F") d = 32'(b - "A") + 10;
      else if (b >= "a" && b <= "f") d = 32'(b - "a") + 10;
      else d = 16;
      if (d >= 16) begin
        // a non-hex byte closes the size field
        if (minus_seen || !digit_seen || size_acc == 0) begin
          pp = P_DONE;
          expected_q.push_back('{data: 8'h00, eob: 1'b1});
        end else begin
          pp = (b == CH_CR) ? P_EXTCR : P_EXT;
        end
      end else begin
        digit_seen = 1'b1;
        if (saturated || size_acc > (SIZE_MAX - d) / 16) begin
          saturated = 1'b1;
          size_acc  = SIZE_MAX;
        end else begin
          size_acc = size_acc * 16 + d;
        end
      end
    end
  endtask

  task automatic send_word(input logic start, input logic [7:0] b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    in_byte      <= b;
    // hold the word until it is taken
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_word(start, b);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(open_body, b);
    open_body = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_body();
    string ws;
    string digits;
    logic [7:0] c;
    int len;
    int n;
    ws = " \t\n";
    open_body = 1'b1;
    if ($urandom_range(0, 7) == 0) begin
      // broken stream: random bytes with the odd restart
      n = $urandom_range(4, 40);
      repeat (n) begin
        send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 15) == 0) open_body = 1'b1;
      end
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 2)) send_byte(ws[$urandom_range(0, 2)]);
      if ($urandom_range(0, 3) == 0) send_byte(CH_PLUS);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      if ($urandom_range(0, 2) == 0) send_text($urandom_range(0, 1) ? "0x" : "0X");
      if ($urandom_range(0, 3) == 0) send_byte(CH_ZERO);
      digits = $sformatf("%0h", len);
      for (int i = 0; i < digits.len(); i++) begin
        c = digits[i];
        if (c >= "a" && $urandom_range(0, 1)) c = c - 8'h20;
        send_byte(c);
      end
      case ($urandom_range(0, 2))
        0: begin
          send_byte(CH_CR);
          if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
          send_byte(CH_LF);
        end
        default: begin
          send_byte($urandom_range(0, 1) ? ";" : " ");
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0) send_text("\rq");
          send_text("\r\n");
        end
      endcase
      repeat (len) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_text("\r\n");
      end
    end
    send_text(body_enders[$urandom_range(0, 5)]);
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    // whitespace, sign, prefix, extension with doubled CR, extreme data bytes
    open_body = 1'b1;
    send_text(" \t\n+0x2;e\r\r\n");
    send_byte(8'h00);
    send_byte(8'hff);
    // lone zero ends the body, then a byte that must be ignored
    send_text("\r\n0\rZ");
    open_body = 1'b1;
    send_text("-5\r");
    open_body = 1'b1;
    send_text("0Xg");
  endtask

  task automatic test_size_limits();
    open_body = 1'b1;
    send_text("7FFFFFFF;\r\n");
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    open_body = 1'b1;
    send_text("7fffffffff\r\n");
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    // no digits at all: CR closes an empty field
    open_body = 1'b1;
    send_text("\r");
  endtask

  task automatic test_pause_mid_chunk();
    open_body = 1'b1;
    send_text("8\r\n");
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    wait_drained();
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    send_text("\r\n0\r\n\r\n");
  endtask

  task automatic test_random_bodies(input int target);
    int first;
    first = words_sent;
    while (words_sent - first < target) send_random_body();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random_bodies(STEADY_WORDS);
    gaps_on = 1'b1;
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    body_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word: out_byte %h out_end_of_body %b", out_byte, out_end_of_body);
        failures++;
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (want.eob) bodies_ended++;
        if (out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, out_byte);
          failures++;
        end
        if (out_end_of_body !== want.eob) begin
          $error("out_end_of_body: expected %b, got %b", want.eob, out_end_of_body);
          failures++;
        end
      end
      stall_left = gaps_on ? $urandom_range(0, 3) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("chunked_body_decoder regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_size_limits();
    test_pause_mid_chunk();
    test_random_bodies(RANDOM_WORDS);
    test_back_to_back();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d parsed bytes and %0d bytes after end of body.", words_sent,
             words_ignored);
    $display("Checked %0d results, %0d of them end markers; %0d mismatches.",
             results_checked, bodies_ended, failures);
    if (failures == 0) begin
      $display("chunked_body_decoder regression: pass");
    end else begin
      $display("chunked_body_decoder regression: fail");
    end
    $finish;
  end

endmodule

// File: chunked_body_decoder.f
rtl/core/cbd_pkg.sv
rtl/core/cbd_in_stage.sv
rtl/core/cbd_parse.sv
rtl/core/cbd_out_stage.sv
rtl/core/chunked_body_decoder.sv
bench/chunked_body_decoder_tb.sv
